// ----- rtl/si2dec_pkg.sv -----
// Shared constants, types and the BCD correction function for the decimal text converter.
package si2dec_pkg;

   localparam int VALUE_W  = 32;
   localparam int CHAR_W   = 8;
   localparam int DIGIT_W  = 4;
   localparam int N_DIGITS = 10;
   localparam int DIDX_W   = $clog2(N_DIGITS);
   localparam int BIT_CNT_W = $clog2(VALUE_W);

   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;

   typedef logic [DIGIT_W-1:0] digit_type;

   // Add three to a BCD digit of five or more, ahead of the next doubling
   function automatic digit_type bcd_adjust(input digit_type d);
      digit_type r;
      if (d >= 4'd5) begin
         r = d + 4'd3;
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

// ----- rtl/signed_int_to_decimal_ascii.sv -----
// Signed 32-bit integer to decimal ASCII text, converted by bit-serial double dabble.
//
// Usage:
//   Input channel (req_valid / req_ready / req_value) takes one signed 32-bit
//   value per transaction. Output channel (rsp_valid / rsp_ready / rsp_char_code /
//   rsp_last) returns its decimal text, most significant character first: a
//   leading '-' for a negative value, then one to ten digits without leading
//   zeros. rsp_last marks the final character of each number.
// Timing:
//   After acceptance the magnitude is shifted into a ten-digit BCD register one
//   bit per cycle, the scan state then finds the leading digit, and then one
//   character is emitted per cycle while the output register is free. req_ready
//   is high only while no item is in progress, so a new value is not taken until
//   the last character of the previous one has entered the output register.
// Reset:
//   Synchronous, active high; drops any item in progress and clears rsp_valid.
// Back-pressure:
//   A character waits in the output register while rsp_ready is low; the
//   emitter pauses and no character is lost or repeated.
module signed_int_to_decimal_ascii (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [si2dec_pkg::VALUE_W-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic        [si2dec_pkg::CHAR_W-1:0]  rsp_char_code,
   output logic                                 rsp_last
);
   import si2dec_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   digit_type            bcd_ff [N_DIGITS];
   digit_type            bcd_in [N_DIGITS];
   digit_type            bcd_adj [N_DIGITS];
   logic                 sign_ff, sign_in;
   logic [DIDX_W-1:0]    idx_ff, idx_in;
   logic [DIDX_W-1:0]    top_idx;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 req_fire;
   logic                 out_free;

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // Per-digit add-3 correction, independent across digits
   always_comb begin
      for (int d = 0; d < N_DIGITS; d++) begin
         bcd_adj[d] = bcd_adjust(bcd_ff[d]);
      end
   end

   // Highest non-zero digit, or the units digit for zero
   always_comb begin
      top_idx = '0;
      for (int d = 0; d < N_DIGITS; d++) begin
         if (bcd_ff[d] != '0) begin
            top_idx = DIDX_W'(d);
         end
      end
   end

   // Sequencer: load, shift 32 bits, find leading digit, emit characters
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mag_in       = mag_ff;
      sign_in      = sign_ff;
      idx_in       = idx_ff;
      bcd_in       = bcd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sign_in = req_value[VALUE_W-1];
               // two's complement magnitude; the most negative value stays 2^31
               mag_in  = req_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(req_value))
                                              : VALUE_W'(req_value);
               cnt_in  = '0;
               for (int d = 0; d < N_DIGITS; d++) begin
                  bcd_in[d] = '0;
               end
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            // shift one magnitude bit into the corrected BCD chain
            bcd_in[0] = {bcd_adj[0][DIGIT_W-2:0], mag_ff[VALUE_W-1]};
            for (int d = 1; d < N_DIGITS; d++) begin
               bcd_in[d] = {bcd_adj[d][DIGIT_W-2:0], bcd_adj[d-1][DIGIT_W-1]};
            end
            mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in   = top_idx;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_char_in = ASCII_MINUS;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  rsp_char_in = ASCII_ZERO + CHAR_W'(bcd_ff[idx_ff]);
                  rsp_last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      mag_ff      <= mag_in;
      sign_ff     <= sign_in;
      idx_ff      <= idx_in;
      bcd_ff      <= bcd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the signed integer to decimal ASCII text converter.
module tb_top;
   import si2dec_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned TAIL_CYCLES = 60;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned POW10 [0:9] = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000,
      32'd100000, 32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};

   // One character of expected decimal text
   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } text_char_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [CHAR_W-1:0]         rsp_char_code;
   logic                      rsp_last;

   logic [VALUE_W-1:0] pending_values [$];
   text_char_type      expected_text [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic        receiver_hold = 1'b0;
   event        hold_off_go;

   int unsigned n_values_converted = 0;
   int unsigned n_chars_checked = 0;
   int unsigned n_failures = 0;
   int unsigned idle_cycles = 0;

   signed_int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   // Clock: 12 time units period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Count a failure; only the first few are printed in full
   function automatic void note_failure(input string msg);
      n_failures++;
      if (n_failures <= MAX_REPORTS) begin
         $display("tb_top: error: %s", msg);
      end
   endfunction

   // Expected text of one value: optional minus, then digits without leading zeros
   function automatic void predict_decimal_text(input logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0] magnitude;
      logic [DIGIT_W-1:0] digit_buf [N_DIGITS];
      int                 n_digits;
      text_char_type      ch;
      n_digits = 0;
      magnitude = raw[VALUE_W-1] ? (32'd0 - raw) : raw;
      // Most negative value: its negation wraps to itself, read as unsigned 2147483648
      do begin
         digit_buf[n_digits] = DIGIT_W'(magnitude % 32'd10);
         magnitude = magnitude / 32'd10;
         n_digits++;
      end while (magnitude != 0 && n_digits < N_DIGITS);
      if (raw[VALUE_W-1]) begin
         ch.char_code = ASCII_MINUS;
         ch.last = 1'b0;
         expected_text.push_back(ch);
      end
      for (int k = n_digits - 1; k >= 0; k--) begin
         ch.char_code = ASCII_ZERO + CHAR_W'(digit_buf[k]);
         ch.last = (k == 0);
         expected_text.push_back(ch);
      end
   endfunction

   // Random value: full-width, by digit count, around powers of ten, or an extreme
   function automatic logic [VALUE_W-1:0] random_value();
      int unsigned        pick;
      int unsigned        n_dig;
      logic [VALUE_W-1:0] mag;
      pick = $urandom_range(9);
      if (pick < 4) begin
         return $urandom();
      end
      n_dig = $urandom_range(9, 1);
      if (pick < 8) begin
         mag = $urandom_range(POW10[n_dig] - 1, POW10[n_dig - 1]);
      end else if (pick == 8) begin
         mag = POW10[n_dig] - $urandom_range(1);
      end else begin
         case ($urandom_range(2))
            0: mag = 32'h8000_0000;
            1: mag = 32'h7fff_ffff;
            default: mag = 32'd0;
         endcase
      end
      return $urandom_range(1) ? (32'd0 - mag) : mag;
   endfunction

   // Driver: offers queued values, predicts the text of each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            predict_decimal_text(req_value);
            n_values_converted++;
         end
         if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_value <= pending_values.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each accepted character against the oldest expectation
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               note_failure($sformatf("unexpected character %0d last %0b",
                                      rsp_char_code, rsp_last));
            end else begin
               want = expected_text.pop_front();
               if (rsp_char_code !== want.char_code) begin
                  note_failure($sformatf("char_code expected %0d got %0d",
                                         want.char_code, rsp_char_code));
               end
               if (rsp_last !== want.last) begin
                  note_failure($sformatf("last expected %0b got %0b (char %0d)",
                                         want.last, rsp_last, want.char_code));
               end
            end
            n_chars_checked++;
         end
         rsp_ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Long receiver hold-off, counted here while the sender keeps offering
   always begin
      @(hold_off_go);
      receiver_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      receiver_hold <= 1'b0;
   end

   // Watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: timeout after %0d idle cycles", idle_cycles);
         $display("tb_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Wait until every queued value is taken and all its text has come back
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_values.size() != 0 || req_valid || expected_text.size() != 0);
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned n_items);
      @(negedge clock);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n_items) pending_values.push_back(random_value());
      wait_drained();
   endtask

   // Stimulus sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed values: zero, extremes, digit-count boundaries, alternating bits
      @(negedge clock);
      pending_values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                         32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                         32'd999999999, -32'sd999999999, -32'sd1000000000, 32'h5555_5555,
                         32'haaaa_aaaa, 32'd123456789, -32'sd123456789, -32'sd5};
      wait_drained();

      run_phase(0, 0, 100);
      run_phase(83, 0, 100);
      run_phase(0, 83, 100);
      run_phase(22, 22, 100);

      // Receiver held off while values keep coming: input must stall
      @(negedge clock);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      -> hold_off_go;
      repeat (20) pending_values.push_back(random_value());
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_text.size() != 0) begin
         note_failure($sformatf("%0d characters never arrived", expected_text.size()));
      end
      $display("tb_top: %0d values converted, %0d characters checked", n_values_converted,
               n_chars_checked);
      $display("tb_top: zero, extremes and every digit count, free-running, both-side stalls");
      if (n_failures == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: %0d failures", n_failures);
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
